@@ sv/gap_pkg.sv @@
// gap_pkg: constants, types and helper functions of the grid A* path planner
// no dependencies; used by the interfaces, the engine and the top level
`default_nettype none

package gap_pkg;

  localparam int unsigned GRID_SIDE  = 12;
  localparam int unsigned OPEN_DEPTH = 144;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned COORD_W = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned CELL_W  = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned OIDX_W  = $clog2(OPEN_DEPTH);
  localparam int unsigned OCNT_W  = $clog2(OPEN_DEPTH + 1);
  localparam int unsigned G_W     = $clog2(CELLS);
  localparam int unsigned HINT_W  = $clog2(2 * GRID_SIDE);
  localparam int unsigned H_W     = FRAC_BITS + HINT_W;
  localparam int unsigned F_W     = G_W + FRAC_BITS + 1;
  localparam int unsigned SQ_N    = 2 * (GRID_SIDE - 1) * (GRID_SIDE - 1) + 1;
  localparam int unsigned D2_W    = $clog2(SQ_N);

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [G_W-1:0]     g;
    logic [H_W-1:0]     h;
  } open_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } parent_t;

  typedef struct packed {
    logic               load;
    logic               start;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;
    logic [3:0]         pas;
  } eng_req_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [CNT_W-1:0]   len;
    logic               path_we;
    logic [CELL_W-1:0]  path_idx;
    logic [COORD_W-1:0] path_x;
    logic [COORD_W-1:0] path_y;
  } eng_rsp_t;

  typedef logic [H_W-1:0] sqrt_tab_t [SQ_N];

  function automatic sqrt_tab_t build_sqrt_tab();
    sqrt_tab_t   t;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bm;
    for (int d = 0; d < SQ_N; d++) begin
      v   = 64'(d) << (2 * FRAC_BITS);
      res = '0;
      bm  = 64'd1 << 62;
      while (bm > v) bm = bm >> 2;
      while (bm != 64'd0) begin
        if (v >= res + bm) begin
          v   = v - (res + bm);
          res = (res >> 1) + bm;
        end else begin
          res = res >> 1;
        end
        bm = bm >> 2;
      end
      t[d] = H_W'(res);
    end
    return t;
  endfunction

  localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

  function automatic logic [CELL_W-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    return CELL_W'(CELL_W'(y) * CELL_W'(GRID_SIDE) + CELL_W'(x));
  endfunction

  function automatic logic in_grid(input logic [COORD_W-1:0] v);
    return {1'b0, v} < (COORD_W + 1)'(GRID_SIDE);
  endfunction

  // euclidean distance by table lookup on dx*dx + dy*dy
  function automatic logic [H_W-1:0] hval(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] gx,
                                          input logic [COORD_W-1:0] gy);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [D2_W-1:0]    d2;
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    d2 = D2_W'(D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy));
    return SQRT_TAB[d2];
  endfunction

endpackage

`default_nettype wire

@@ sv/gap_if.sv @@
// gap_in_if and gap_out_if: valid/ready channels of the path planner
// depends on gap_pkg
`default_nettype none

interface gap_in_if;
  logic                         valid;
  logic                         ready;
  logic [gap_pkg::MODE_W-1:0]   mode;
  logic [gap_pkg::COORD_W-1:0]  cell_x;
  logic [gap_pkg::COORD_W-1:0]  cell_y;
  logic [gap_pkg::COORD_W-1:0]  goal_x;
  logic [gap_pkg::COORD_W-1:0]  goal_y;
  logic [3:0]                   passages;
  logic [gap_pkg::STEP_W-1:0]   step_index;

  modport source (output valid, mode, cell_x, cell_y, goal_x, goal_y, passages, step_index,
                  input ready);
  modport sink (input valid, mode, cell_x, cell_y, goal_x, goal_y, passages, step_index,
                output ready);
endinterface

interface gap_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [gap_pkg::LEN_W-1:0]    path_length;
  logic                         step_valid;
  logic [gap_pkg::COORD_W-1:0]  step_x;
  logic [gap_pkg::COORD_W-1:0]  step_y;

  modport source (output valid, found, path_length, step_valid, step_x, step_y,
                  input ready);
  modport sink (input valid, found, path_length, step_valid, step_x, step_y,
                output ready);
endinterface

`default_nettype wire

@@ sv/gap_ram.sv @@
// gap_ram: generic single write port memory with registered read
// no dependencies
`default_nettype none

module gap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/gap_engine.sv @@
// gap_engine: passage map and A* search sequencer around one open list scan unit
// depends on gap_pkg and gap_ram
`default_nettype none

module gap_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gap_pkg::eng_req_t req_i,
  output gap_pkg::eng_rsp_t      rsp_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_SEL   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_POPRD = 4'd5;
  localparam logic [3:0] S_POPWR = 4'd6;
  localparam logic [3:0] S_NBR   = 4'd7;
  localparam logic [3:0] S_CLCHK = 4'd8;
  localparam logic [3:0] S_FIND  = 4'd9;
  localparam logic [3:0] S_CNTRD = 4'd10;
  localparam logic [3:0] S_CNTCK = 4'd11;
  localparam logic [3:0] S_WRRD  = 4'd12;
  localparam logic [3:0] S_WRCK  = 4'd13;

  localparam int unsigned CW = gap_pkg::COORD_W;

  logic [3:0]                   st_q;
  logic [gap_pkg::OCNT_W-1:0]   cnt_q;
  logic [gap_pkg::OCNT_W-1:0]   si_q;
  logic                         sv_q;
  logic [gap_pkg::OIDX_W-1:0]   sidx_q;
  logic [gap_pkg::OIDX_W-1:0]   best_idx_q;
  gap_pkg::open_t               best_q;
  logic [gap_pkg::F_W-1:0]      best_f_q;
  gap_pkg::open_t               cur_q;
  logic [CW-1:0]                sx_q, sy_q, gx_q, gy_q;
  logic [3:0]                   pas_q;
  logic [1:0]                   dir_q;
  logic [CW-1:0]                nx_q, ny_q;
  logic [gap_pkg::H_W-1:0]      nh_q;
  logic [gap_pkg::CELL_W-1:0]   ca_q;
  logic [CW-1:0]                cx_q, cy_q;
  logic [gap_pkg::CNT_W-1:0]    tot_q, n_q;
  logic                         done_q, found_q;
  logic                         done_d;
  logic [gap_pkg::CNT_W-1:0]    len_q;
  logic [gap_pkg::CELLS-1:0]    pv_q;

  logic                         o_we;
  logic [gap_pkg::OIDX_W-1:0]   o_waddr, o_raddr;
  gap_pkg::open_t               o_wdata, o_rdata;
  logic                         c_we, c_wdata, c_rdata;
  logic [gap_pkg::CELL_W-1:0]   c_waddr, c_raddr;
  logic                         pa_we;
  logic [gap_pkg::CELL_W-1:0]   pa_waddr, pa_raddr;
  gap_pkg::parent_t             pa_wdata, pa_rdata;
  logic                         p_we;
  logic [gap_pkg::CELL_W-1:0]   p_waddr, p_raddr;
  logic [3:0]                   p_rdata;

  logic                         nb_ok;
  logic [CW-1:0]                nbx, nby;
  logic [gap_pkg::G_W-1:0]      tg;
  logic [gap_pkg::F_W-1:0]      ent_f;
  logic                         issue, hit, scan_end, last_dir, better;

  assign tg       = cur_q.g + gap_pkg::G_W'(1);
  assign ent_f    = (gap_pkg::F_W'(o_rdata.g) << gap_pkg::FRAC_BITS)
                    + gap_pkg::F_W'(o_rdata.h);
  assign issue    = si_q < cnt_q;
  assign scan_end = !issue && !sv_q;
  assign hit      = sv_q && (o_rdata.x == nx_q) && (o_rdata.y == ny_q);
  assign better   = tg < o_rdata.g;
  assign last_dir = dir_q == gap_pkg::DIR_W;

  always_comb begin
    nbx   = cur_q.x;
    nby   = cur_q.y;
    nb_ok = 1'b0;
    case (dir_q)
      gap_pkg::DIR_N: begin
        nby   = cur_q.y + CW'(1);
        nb_ok = pas_q[0] && (cur_q.y != CW'(gap_pkg::GRID_SIDE - 1));
      end
      gap_pkg::DIR_S: begin
        nby   = cur_q.y - CW'(1);
        nb_ok = pas_q[1] && (cur_q.y != '0);
      end
      gap_pkg::DIR_E: begin
        nbx   = cur_q.x + CW'(1);
        nb_ok = pas_q[2] && (cur_q.x != CW'(gap_pkg::GRID_SIDE - 1));
      end
      default: begin
        nbx   = cur_q.x - CW'(1);
        nb_ok = pas_q[3] && (cur_q.x != '0);
      end
    endcase
  end

  always_comb begin
    case (st_q)
      S_IDLE: begin
        done_d = req_i.start &&
                 !(gap_pkg::in_grid(req_i.x) && gap_pkg::in_grid(req_i.y) &&
                   gap_pkg::in_grid(req_i.gx) && gap_pkg::in_grid(req_i.gy));
      end
      S_SEL: begin
        done_d = cnt_q == '0;
      end
      S_WRCK: begin
        done_d = !pa_rdata.valid || (n_q == tot_q);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    o_we     = 1'b0;
    o_waddr  = '0;
    o_wdata  = o_rdata;
    o_raddr  = si_q[gap_pkg::OIDX_W-1:0];
    c_we     = 1'b0;
    c_waddr  = gap_pkg::cell_idx(cur_q.x, cur_q.y);
    c_wdata  = 1'b1;
    c_raddr  = gap_pkg::cell_idx(nbx, nby);
    pa_we    = 1'b0;
    pa_waddr = gap_pkg::cell_idx(nx_q, ny_q);
    pa_wdata = '{valid: 1'b1, x: cur_q.x, y: cur_q.y};
    pa_raddr = gap_pkg::cell_idx(cx_q, cy_q);
    p_we     = req_i.load && gap_pkg::in_grid(req_i.x) && gap_pkg::in_grid(req_i.y);
    p_waddr  = gap_pkg::cell_idx(req_i.x, req_i.y);
    p_raddr  = gap_pkg::cell_idx(best_q.x, best_q.y);
    case (st_q)
      S_CLR: begin
        c_we     = 1'b1;
        c_waddr  = ca_q;
        c_wdata  = 1'b0;
        pa_we    = 1'b1;
        pa_waddr = ca_q;
        pa_wdata = '0;
      end
      S_INIT: begin
        o_we    = 1'b1;
        o_waddr = '0;
        o_wdata = '{x: sx_q, y: sy_q, g: '0, h: gap_pkg::hval(sx_q, sy_q, gx_q, gy_q)};
      end
      S_POPRD: begin
        o_raddr = gap_pkg::OIDX_W'(cnt_q - gap_pkg::OCNT_W'(1));
      end
      S_POPWR: begin
        o_we    = 1'b1;
        o_waddr = best_idx_q;
        c_we    = 1'b1;
      end
      S_FIND: begin
        if (hit) begin
          o_we    = better;
          o_waddr = sidx_q;
          o_wdata = '{x: nx_q, y: ny_q, g: tg, h: o_rdata.h};
          pa_we   = better;
        end else if (scan_end && (cnt_q < gap_pkg::OCNT_W'(gap_pkg::OPEN_DEPTH))) begin
          o_we    = 1'b1;
          o_waddr = cnt_q[gap_pkg::OIDX_W-1:0];
          o_wdata = '{x: nx_q, y: ny_q, g: tg, h: nh_q};
          pa_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      cnt_q      <= '0;
      si_q       <= '0;
      sv_q       <= 1'b0;
      sidx_q     <= '0;
      best_idx_q <= '0;
      best_q     <= '0;
      best_f_q   <= '0;
      cur_q      <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      gx_q       <= '0;
      gy_q       <= '0;
      pas_q      <= '0;
      dir_q      <= '0;
      nx_q       <= '0;
      ny_q       <= '0;
      nh_q       <= '0;
      ca_q       <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      tot_q      <= '0;
      n_q        <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      len_q      <= '0;
      pv_q       <= '0;
    end else begin
      done_q <= done_d;
      if (p_we) begin
        pv_q[p_waddr] <= 1'b1;
      end
      case (st_q)
        S_IDLE: begin
          if (req_i.start) begin
            sx_q <= req_i.x;
            sy_q <= req_i.y;
            gx_q <= req_i.gx;
            gy_q <= req_i.gy;
            ca_q <= '0;
            if (gap_pkg::in_grid(req_i.x) && gap_pkg::in_grid(req_i.y) &&
                gap_pkg::in_grid(req_i.gx) && gap_pkg::in_grid(req_i.gy)) begin
              st_q <= S_CLR;
            end else begin
              found_q <= 1'b0;
              len_q   <= '0;
            end
          end
        end
        S_CLR: begin
          ca_q <= ca_q + gap_pkg::CELL_W'(1);
          if (ca_q == gap_pkg::CELL_W'(gap_pkg::CELLS - 1)) begin
            st_q <= S_INIT;
          end
        end
        S_INIT: begin
          cnt_q <= gap_pkg::OCNT_W'(1);
          st_q  <= S_SEL;
        end
        S_SEL: begin
          si_q <= '0;
          sv_q <= 1'b0;
          if (cnt_q == '0) begin
            found_q <= 1'b0;
            len_q   <= '0;
            st_q    <= S_IDLE;
          end else begin
            st_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          sv_q   <= issue;
          sidx_q <= si_q[gap_pkg::OIDX_W-1:0];
          if (issue) begin
            si_q <= si_q + gap_pkg::OCNT_W'(1);
          end
          if (sv_q && ((sidx_q == '0) || (ent_f < best_f_q))) begin
            best_q     <= o_rdata;
            best_f_q   <= ent_f;
            best_idx_q <= sidx_q;
          end
          if (scan_end) begin
            st_q <= S_POPRD;
          end
        end
        S_POPRD: begin
          cur_q <= best_q;
          cnt_q <= cnt_q - gap_pkg::OCNT_W'(1);
          st_q  <= S_POPWR;
        end
        S_POPWR: begin
          pas_q <= pv_q[gap_pkg::cell_idx(cur_q.x, cur_q.y)] ? p_rdata : 4'd0;
          dir_q <= '0;
          if ((cur_q.x == gx_q) && (cur_q.y == gy_q)) begin
            cx_q  <= cur_q.x;
            cy_q  <= cur_q.y;
            tot_q <= '0;
            st_q  <= S_CNTRD;
          end else begin
            st_q <= S_NBR;
          end
        end
        S_NBR: begin
          if (nb_ok) begin
            nx_q <= nbx;
            ny_q <= nby;
            nh_q <= gap_pkg::hval(nbx, nby, gx_q, gy_q);
            st_q <= S_CLCHK;
          end else if (last_dir) begin
            st_q <= S_SEL;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        S_CLCHK: begin
          si_q <= '0;
          sv_q <= 1'b0;
          if (!c_rdata) begin
            st_q <= S_FIND;
          end else if (last_dir) begin
            st_q <= S_SEL;
          end else begin
            dir_q <= dir_q + 2'd1;
            st_q  <= S_NBR;
          end
        end
        S_FIND: begin
          sv_q   <= issue;
          sidx_q <= si_q[gap_pkg::OIDX_W-1:0];
          if (issue) begin
            si_q <= si_q + gap_pkg::OCNT_W'(1);
          end
          if (hit || scan_end) begin
            if (!hit && (cnt_q < gap_pkg::OCNT_W'(gap_pkg::OPEN_DEPTH))) begin
              cnt_q <= cnt_q + gap_pkg::OCNT_W'(1);
            end
            if (last_dir) begin
              st_q <= S_SEL;
            end else begin
              dir_q <= dir_q + 2'd1;
              st_q  <= S_NBR;
            end
          end
        end
        S_CNTRD: begin
          tot_q <= tot_q + gap_pkg::CNT_W'(1);
          st_q  <= S_CNTCK;
        end
        S_CNTCK: begin
          if (!pa_rdata.valid || (tot_q == gap_pkg::CNT_W'(gap_pkg::CELLS))) begin
            cx_q <= gx_q;
            cy_q <= gy_q;
            n_q  <= '0;
            st_q <= S_WRRD;
          end else begin
            cx_q <= pa_rdata.x;
            cy_q <= pa_rdata.y;
            st_q <= S_CNTRD;
          end
        end
        S_WRRD: begin
          n_q  <= n_q + gap_pkg::CNT_W'(1);
          st_q <= S_WRCK;
        end
        S_WRCK: begin
          if (!pa_rdata.valid || (n_q == tot_q)) begin
            found_q <= 1'b1;
            len_q   <= tot_q;
            st_q    <= S_IDLE;
          end else begin
            cx_q <= pa_rdata.x;
            cy_q <= pa_rdata.y;
            st_q <= S_WRRD;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  gap_ram #(.WIDTH($bits(gap_pkg::open_t)), .DEPTH(gap_pkg::OPEN_DEPTH)) u_open_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .raddr_i(o_raddr),
    .rdata_o(o_rdata)
  );

  gap_ram #(.WIDTH(1), .DEPTH(gap_pkg::CELLS)) u_closed_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  gap_ram #(.WIDTH($bits(gap_pkg::parent_t)), .DEPTH(gap_pkg::CELLS)) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (pa_we),
    .waddr_i(pa_waddr),
    .wdata_i(pa_wdata),
    .raddr_i(pa_raddr),
    .rdata_o(pa_rdata)
  );

  gap_ram #(.WIDTH(4), .DEPTH(gap_pkg::CELLS)) u_pass_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(req_i.pas),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  always_comb begin
    rsp_o.done     = done_q;
    rsp_o.found    = found_q;
    rsp_o.len      = len_q;
    rsp_o.path_we  = st_q == S_WRRD;
    rsp_o.path_idx = gap_pkg::CELL_W'(tot_q - gap_pkg::CNT_W'(1) - n_q);
    rsp_o.path_x   = cx_q;
    rsp_o.path_y   = cy_q;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= gap_pkg::OCNT_W'(gap_pkg::OPEN_DEPTH))
    else $error("open list count beyond depth");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && found_q |-> len_q != '0)
    else $error("path found with zero length");

  a_miss_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !found_q |-> len_q == '0)
    else $error("failed plan with nonzero length");

  a_path_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_WRRD |-> n_q < tot_q)
    else $error("path write beyond chain length");

  a_pop_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_POPRD |-> gap_pkg::OCNT_W'(best_idx_q) < cnt_q)
    else $error("popped entry outside open list");

endmodule

`default_nettype wire

@@ sv/grid_astar_path_planner_top.sv @@
// grid_astar_path_planner_top: handshake, mode decode, path store and result register
// depends on gap_pkg, gap_if, gap_ram and gap_engine
//
//   channel  direction  payload
//   in_i     sink       mode, cell_x, cell_y, goal_x, goal_y, passages, step_index
//   out_o    source     found, path_length, step_valid, step_x, step_y
//
// load and mode three give their result in the cycle after the transfer, read goes via
// the T_READ state; a plan with a start or goal off the grid skips the search, otherwise
// a clear of all 144 cells of the closed and parent stores, then per popped cell one
// pass over the open list plus up to four membership passes, one entry per cycle
// through the open list memory port
// reset clears control state and the passage map; in_i is held off while an item is
// at work and while a result waits on out_o with ready low
`default_nettype none

module grid_astar_path_planner_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gap_in_if.sink    in_i,
  gap_out_if.source out_o
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_PLAN = 2'd1;
  localparam logic [1:0] T_READ = 2'd2;

  localparam int unsigned CMP_W = gap_pkg::CNT_W + gap_pkg::STEP_W;

  logic [1:0]                  st_q;
  logic                        ov_q;
  logic                        ov_d;
  logic                        found_q;
  logic [gap_pkg::LEN_W-1:0]   len_q;
  logic                        sv_q;
  logic [gap_pkg::COORD_W-1:0] x_q, y_q;
  logic                        rd_ok_q;
  logic                        acc;
  gap_pkg::eng_req_t           req;
  gap_pkg::eng_rsp_t           rsp;
  logic [2*gap_pkg::COORD_W-1:0] path_rdata;

  assign in_i.ready = (st_q == T_IDLE) && (!ov_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    req.load  = acc && (in_i.mode == gap_pkg::MODE_LOAD);
    req.start = acc && (in_i.mode == gap_pkg::MODE_PLAN);
    req.x     = in_i.cell_x;
    req.y     = in_i.cell_y;
    req.gx    = in_i.goal_x;
    req.gy    = in_i.goal_y;
    req.pas   = in_i.passages;
  end

  always_comb begin
    ov_d = ov_q;
    if (out_o.valid && out_o.ready) begin
      ov_d = 1'b0;
    end
    case (st_q)
      T_IDLE: begin
        if (acc && (in_i.mode != gap_pkg::MODE_PLAN) &&
            (in_i.mode != gap_pkg::MODE_READ)) begin
          ov_d = 1'b1;
        end
      end
      T_PLAN: begin
        if (rsp.done) begin
          ov_d = 1'b1;
        end
      end
      T_READ: begin
        ov_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gap_engine u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  gap_ram #(.WIDTH(2 * gap_pkg::COORD_W), .DEPTH(gap_pkg::CELLS)) u_path_ram (
    .clk_i  (clk_i),
    .we_i   (rsp.path_we),
    .waddr_i(rsp.path_idx),
    .wdata_i({rsp.path_x, rsp.path_y}),
    .raddr_i(gap_pkg::CELL_W'(in_i.step_index)),
    .rdata_o(path_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= T_IDLE;
      ov_q    <= 1'b0;
      found_q <= 1'b0;
      len_q   <= '0;
      sv_q    <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      case (st_q)
        T_IDLE: begin
          if (acc) begin
            case (in_i.mode)
              gap_pkg::MODE_PLAN: begin
                st_q <= T_PLAN;
              end
              gap_pkg::MODE_READ: begin
                rd_ok_q <= CMP_W'(in_i.step_index) < CMP_W'(rsp.len);
                st_q    <= T_READ;
              end
              default: begin
                found_q <= rsp.found;
                len_q   <= gap_pkg::LEN_W'(rsp.len);
                sv_q    <= 1'b0;
                x_q     <= '0;
                y_q     <= '0;
              end
            endcase
          end
        end
        T_PLAN: begin
          if (rsp.done) begin
            found_q <= rsp.found;
            len_q   <= gap_pkg::LEN_W'(rsp.len);
            sv_q    <= 1'b0;
            x_q     <= '0;
            y_q     <= '0;
            st_q    <= T_IDLE;
          end
        end
        T_READ: begin
          found_q <= rsp.found;
          len_q   <= gap_pkg::LEN_W'(rsp.len);
          sv_q    <= rd_ok_q;
          x_q     <= rd_ok_q ? path_rdata[2*gap_pkg::COORD_W-1:gap_pkg::COORD_W] : '0;
          y_q     <= rd_ok_q ? path_rdata[gap_pkg::COORD_W-1:0] : '0;
          st_q    <= T_IDLE;
        end
        default: begin
          st_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.found       = found_q;
  assign out_o.path_length = len_q;
  assign out_o.step_valid  = sv_q;
  assign out_o.step_x      = x_q;
  assign out_o.step_y      = y_q;

endmodule

`default_nettype wire
